/* sv/stereo_comb_allpass_reverb_top_defines.svh */
`ifndef STEREO_COMB_ALLPASS_REVERB_TOP_DEFINES_SVH
`define STEREO_COMB_ALLPASS_REVERB_TOP_DEFINES_SVH

// Assertion helpers; both sample on clk and need clk in scope, and SCR_ASSERT also needs rst_n.
`ifndef SYNTHESIS
`define SCR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scr assertion failed");
`define SCR_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("scr reset assertion failed");
`else
`define SCR_ASSERT(lbl, prop)
`define SCR_ASSERT_RST(lbl, prop)
`endif

`endif

/* sv/scr_pkg.sv */
`timescale 1ns / 1ps
package scr_pkg;

    localparam int SAMPLE_RATE   = 44100;
    localparam int COMB_COUNT    = 8;
    localparam int ALLPASS_COUNT = 4;
    localparam int RIGHT_OFFSET  = 23;

    localparam int COMB_BASE [8] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
    localparam int AP_BASE   [4] = '{556, 441, 341, 225};

    function automatic int scaled_len(input int base);
        int n;
        n = (base * SAMPLE_RATE) / 44100;
        return (n == 0) ? 1 : n;
    endfunction

    localparam int CL_DEPTH = (11024 * SAMPLE_RATE) / 44100 + 1;
    localparam int CR_DEPTH = ((11024 + 8 * RIGHT_OFFSET) * SAMPLE_RATE) / 44100 + 1;
    localparam int AL_DEPTH = (1563 * SAMPLE_RATE) / 44100 + 1;
    localparam int AR_DEPTH = ((1563 + 4 * RIGHT_OFFSET) * SAMPLE_RATE) / 44100 + 1;

    localparam int CLA_W = $clog2(CL_DEPTH);
    localparam int CRA_W = $clog2(CR_DEPTH);
    localparam int ALA_W = $clog2(AL_DEPTH);
    localparam int ARA_W = $clog2(AR_DEPTH);

    // position widths hold the line length itself
    localparam int CP_W = $clog2(scaled_len(1617 + RIGHT_OFFSET) + 1);
    localparam int AP_W = $clog2(scaled_len(556 + RIGHT_OFFSET) + 1);

    localparam int K_W   = 4;
    localparam int SMP_W = 24;
    localparam int SUM_W = 27;
    localparam int SAT_W = 48;
    localparam int MA_W  = 26;
    localparam int MB_W  = 18;
    localparam int MP_W  = MA_W + MB_W;
    localparam int ACC_W = 58;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic signed [SAT_W-1:0] S24_MAX = SAT_W'(8388607);
    localparam logic signed [SAT_W-1:0] S24_MIN = -SAT_W'(8388608);
    localparam logic signed [ACC_W-1:0] S16_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] S16_MIN = -ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] RND16   = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] RND28   = ACC_W'(134217728);

    typedef enum logic [2:0] {
        CFG_ROOM_FEEDBACK = 3'd0,
        CFG_DAMPING_GAIN  = 3'd1,
        CFG_WET_MIX       = 3'd2,
        CFG_WET_SCALE     = 3'd3
    } cfg_idx_t;

    typedef logic [CRA_W-1:0] comb_off_tab_t [16];
    typedef logic [CP_W-1:0]  comb_len_tab_t [16];
    typedef logic [CRA_W-1:0] ap_off_tab_t [8];
    typedef logic [AP_W-1:0]  ap_len_tab_t [8];

    function automatic comb_off_tab_t comb_off_tab();
        comb_off_tab_t t;
        int ol;
        int orr;
        ol  = 0;
        orr = 0;
        for (int k = 0; k < 8; k++) begin
            t[k]     = CRA_W'(ol);
            t[k + 8] = CRA_W'(orr);
            if (k < COMB_COUNT) begin
                ol  = ol + scaled_len(COMB_BASE[k]);
                orr = orr + scaled_len(COMB_BASE[k] + RIGHT_OFFSET);
            end
        end
        return t;
    endfunction

    function automatic comb_len_tab_t comb_len_tab();
        comb_len_tab_t t;
        for (int k = 0; k < 8; k++) begin
            t[k]     = (k < COMB_COUNT) ? CP_W'(scaled_len(COMB_BASE[k])) : CP_W'(1);
            t[k + 8] = (k < COMB_COUNT) ?
                       CP_W'(scaled_len(COMB_BASE[k] + RIGHT_OFFSET)) : CP_W'(1);
        end
        return t;
    endfunction

    function automatic ap_off_tab_t ap_off_tab();
        ap_off_tab_t t;
        int ol;
        int orr;
        ol  = 0;
        orr = 0;
        for (int k = 0; k < 4; k++) begin
            t[k]     = CRA_W'(ol);
            t[k + 4] = CRA_W'(orr);
            if (k < ALLPASS_COUNT) begin
                ol  = ol + scaled_len(AP_BASE[k]);
                orr = orr + scaled_len(AP_BASE[k] + RIGHT_OFFSET);
            end
        end
        return t;
    endfunction

    function automatic ap_len_tab_t ap_len_tab();
        ap_len_tab_t t;
        for (int k = 0; k < 4; k++) begin
            t[k]     = (k < ALLPASS_COUNT) ? AP_W'(scaled_len(AP_BASE[k])) : AP_W'(1);
            t[k + 4] = (k < ALLPASS_COUNT) ?
                       AP_W'(scaled_len(AP_BASE[k] + RIGHT_OFFSET)) : AP_W'(1);
        end
        return t;
    endfunction

    localparam comb_off_tab_t COMB_OFF = comb_off_tab();
    localparam comb_len_tab_t COMB_LEN = comb_len_tab();
    localparam ap_off_tab_t   AP_OFF   = ap_off_tab();
    localparam ap_len_tab_t   AP_LEN   = ap_len_tab();

    function automatic logic signed [SMP_W-1:0] sat24_f(input logic signed [SAT_W-1:0] x);
        logic signed [SMP_W-1:0] r;
        if (x > S24_MAX) begin
            r = 24'sh7FFFFF;
        end
        else if (x < S24_MIN) begin
            r = 24'sh800000;
        end
        else begin
            r = x[SMP_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16_f(input logic signed [ACC_W-1:0] x);
        logic signed [15:0] r;
        if (x > S16_MAX) begin
            r = 16'sh7FFF;
        end
        else if (x < S16_MIN) begin
            r = 16'sh8000;
        end
        else begin
            r = x[15:0];
        end
        return r;
    endfunction

    typedef enum logic [1:0] {
        SH_0,
        SH_12,
        SH_17
    } mac_sh_t;

    typedef struct packed {
        logic                   issue;
        logic                   clr;
        mac_sh_t                sh;
        logic signed [MA_W-1:0] a;
        logic signed [MB_W-1:0] b;
    } mac_op_t;

    typedef struct packed {
        logic [15:0] room_feedback;
        logic [15:0] damping_gain;
        logic [15:0] wet_mix;
        logic [15:0] wet_scale;
    } scr_cfg_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
    } scr_res_t;

endpackage

/* sv/scr_ram.sv */
`timescale 1ns / 1ps
module scr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

/* sv/scr_mac.sv */
`timescale 1ns / 1ps
`include "stereo_comb_allpass_reverb_top_defines.svh"
module scr_mac import scr_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_op_t                 op,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [MP_W-1:0]  prod_reg;
    logic                    pv_reg;
    logic                    pclr_reg;
    mac_sh_t                 psh_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] shifted;
    logic signed [MA_W-1:0]  op_a;
    logic signed [MB_W-1:0]  op_b;

    assign op_a     = $signed(op.a);
    assign op_b     = $signed(op.b);
    assign prod_ext = ACC_W'(prod_reg);

    always_comb
    begin
        unique case (psh_reg)
            SH_12:   shifted = prod_ext <<< 12;
            SH_17:   shifted = prod_ext <<< 17;
            default: shifted = prod_ext;
        endcase
    end

    // product stage, then shift-accumulate stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg   <= 1'b0;
            pclr_reg <= 1'b0;
            psh_reg  <= SH_0;
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            pv_reg <= op.issue;
            if (op.issue)
            begin
                prod_reg <= op_a * op_b;
                pclr_reg <= op.clr;
                psh_reg  <= op.sh;
            end
            if (pv_reg)
            begin
                acc_reg <= (pclr_reg ? '0 : acc_reg) + shifted;
            end
        end
    end

    assign acc = acc_reg;

    `SCR_ASSERT(a_acc_hold, !pv_reg |=> $stable(acc_reg))
    `SCR_ASSERT(a_issue_pend, op.issue |=> pv_reg)
    `SCR_ASSERT(a_idle_pend, !op.issue |=> !pv_reg)

endmodule

/* sv/scr_core.sv */
`timescale 1ns / 1ps
`include "stereo_comb_allpass_reverb_top_defines.svh"
module scr_core import scr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  scr_cfg_t           cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] left_in,
    input  logic signed [15:0] right_in,
    input  logic               last_in,
    output logic               fin_valid,
    input  logic               fin_ready,
    output scr_res_t           fin
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_C_RD,
        S_C_M1,
        S_C_M2,
        S_C_W1,
        S_C_ST,
        S_C_M3,
        S_C_W2,
        S_C_WR,
        S_A_RD,
        S_A_WR,
        S_X_M1,
        S_X_W1,
        S_X_HI,
        S_X_LO,
        S_X_DRY,
        S_X_W2,
        S_X_OUT,
        S_DONE
    } state_t;

    state_t                   state_reg;
    logic [CRA_W-1:0]         clr_reg;
    logic                     ch_reg;
    logic [K_W-1:0]           k_reg;
    logic signed [15:0]       left_reg;
    logic signed [15:0]       right_reg;
    logic                     last_reg;
    logic signed [15:0]       mono_reg;
    logic signed [SMP_W-1:0]  st_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SMP_W-1:0]  v_reg;
    logic signed [15:0]       res_l_reg;
    logic signed [15:0]       res_r_reg;
    logic signed [SMP_W-1:0]  damp_reg [16];
    logic [CP_W-1:0]          cpos_reg [16];
    logic [AP_W-1:0]          apos_reg [8];

    logic [3:0]               cidx;
    logic [2:0]               aidx;
    logic [CP_W-1:0]          cpos_inc;
    logic [CP_W-1:0]          cpos_next;
    logic [AP_W-1:0]          apos_inc;
    logic [AP_W-1:0]          apos_next;
    logic [CRA_W-1:0]         comb_addr;
    logic [CRA_W-1:0]         ap_addr;
    logic                     clearing;
    logic                     cl_we;
    logic                     cr_we;
    logic                     al_we;
    logic                     ar_we;
    logic [SMP_W-1:0]         comb_wdata;
    logic [SMP_W-1:0]         ap_wdata;
    logic [SMP_W-1:0]         cl_rdata;
    logic [SMP_W-1:0]         cr_rdata;
    logic [SMP_W-1:0]         al_rdata;
    logic [SMP_W-1:0]         ar_rdata;
    logic signed [SMP_W-1:0]  comb_rd;
    logic signed [SMP_W-1:0]  ap_b;
    logic signed [SMP_W-1:0]  ap_out;
    logic signed [SMP_W-1:0]  ap_wval;
    logic signed [SMP_W-1:0]  st_val;
    logic signed [SMP_W-1:0]  comb_wval;
    logic signed [SMP_W-1:0]  sum_sat;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_r16;
    logic signed [ACC_W-1:0]  acc_r28;
    logic signed [15:0]       mix_val;
    logic signed [16:0]       lr_sum;
    logic signed [15:0]       dry;
    logic [16:0]              one_m_damp;
    logic [16:0]              one_m_mix;
    mac_op_t                  mac_op;

    assign cidx      = {ch_reg, k_reg[2:0]};
    assign aidx      = {ch_reg, k_reg[1:0]};
    assign clearing  = (state_reg == S_CLEAR);
    assign cpos_inc  = cpos_reg[cidx] + CP_W'(1);
    assign cpos_next = (cpos_inc == COMB_LEN[cidx]) ? '0 : cpos_inc;
    assign apos_inc  = apos_reg[aidx] + AP_W'(1);
    assign apos_next = (apos_inc == AP_LEN[aidx]) ? '0 : apos_inc;

    assign comb_addr = clearing ? clr_reg : COMB_OFF[cidx] + CRA_W'(cpos_reg[cidx]);
    assign ap_addr   = clearing ? clr_reg : AP_OFF[aidx] + CRA_W'(apos_reg[aidx]);

    // during the clearing pass every line is swept with zeros
    assign cl_we = clearing ? ({1'b0, clr_reg} < (CRA_W + 1)'(CL_DEPTH))
                            : (state_reg == S_C_WR && !ch_reg);
    assign cr_we = clearing ? 1'b1 : (state_reg == S_C_WR && ch_reg);
    assign al_we = clearing ? ({1'b0, clr_reg} < (CRA_W + 1)'(AL_DEPTH))
                            : (state_reg == S_A_WR && !ch_reg);
    assign ar_we = clearing ? ({1'b0, clr_reg} < (CRA_W + 1)'(AR_DEPTH))
                            : (state_reg == S_A_WR && ch_reg);
    assign comb_wdata = clearing ? '0 : comb_wval;
    assign ap_wdata   = clearing ? '0 : ap_wval;

    scr_ram #(.DEPTH(CL_DEPTH), .WIDTH(SMP_W), .AW(CLA_W)) u_comb_l (
        .clk   (clk),
        .we    (cl_we),
        .re    (state_reg == S_C_RD && !ch_reg),
        .addr  (comb_addr[CLA_W-1:0]),
        .wdata (comb_wdata),
        .rdata (cl_rdata)
    );

    scr_ram #(.DEPTH(CR_DEPTH), .WIDTH(SMP_W), .AW(CRA_W)) u_comb_r (
        .clk   (clk),
        .we    (cr_we),
        .re    (state_reg == S_C_RD && ch_reg),
        .addr  (comb_addr),
        .wdata (comb_wdata),
        .rdata (cr_rdata)
    );

    scr_ram #(.DEPTH(AL_DEPTH), .WIDTH(SMP_W), .AW(ALA_W)) u_ap_l (
        .clk   (clk),
        .we    (al_we),
        .re    (state_reg == S_A_RD && !ch_reg),
        .addr  (ap_addr[ALA_W-1:0]),
        .wdata (ap_wdata),
        .rdata (al_rdata)
    );

    scr_ram #(.DEPTH(AR_DEPTH), .WIDTH(SMP_W), .AW(ARA_W)) u_ap_r (
        .clk   (clk),
        .we    (ar_we),
        .re    (state_reg == S_A_RD && ch_reg),
        .addr  (ap_addr[ARA_W-1:0]),
        .wdata (ap_wdata),
        .rdata (ar_rdata)
    );

    scr_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .acc   (acc)
    );

    assign comb_rd = $signed(ch_reg ? cr_rdata : cl_rdata);
    assign ap_b    = $signed(ch_reg ? ar_rdata : al_rdata);

    assign acc_r16   = (acc + RND16) >>> 16;
    assign acc_r28   = (acc + RND28) >>> 28;
    assign st_val    = sat24_f(SAT_W'(acc_r16));
    assign comb_wval = sat24_f(SAT_W'(mono_reg) + SAT_W'(acc_r16));
    assign ap_out    = sat24_f(SAT_W'(ap_b) - SAT_W'(v_reg));
    assign ap_wval   = sat24_f(SAT_W'(v_reg) + SAT_W'(ap_b >>> 1));
    assign sum_sat   = sat24_f(SAT_W'(sum_reg));
    assign mix_val   = sat16_f(acc_r28);
    assign lr_sum    = 17'(left_in) + 17'(right_in);
    assign dry       = ch_reg ? right_reg : left_reg;

    assign one_m_damp = ONE_Q16 - {1'b0, cfg.damping_gain};
    assign one_m_mix  = ONE_Q16 - {1'b0, cfg.wet_mix};

    always_comb
    begin
        mac_op       = '0;
        mac_op.sh    = SH_0;
        unique case (state_reg)
            S_C_M1:
            begin
                mac_op.issue = 1'b1;
                mac_op.clr   = 1'b1;
                mac_op.a     = MA_W'(comb_rd);
                mac_op.b     = $signed({1'b0, one_m_damp});
            end
            S_C_M2:
            begin
                mac_op.issue = 1'b1;
                mac_op.a     = MA_W'(damp_reg[cidx]);
                mac_op.b     = $signed({2'b00, cfg.damping_gain});
            end
            S_C_M3:
            begin
                mac_op.issue = 1'b1;
                mac_op.clr   = 1'b1;
                mac_op.a     = MA_W'(st_reg);
                mac_op.b     = $signed({2'b00, cfg.room_feedback});
            end
            S_X_M1:
            begin
                mac_op.issue = 1'b1;
                mac_op.clr   = 1'b1;
                mac_op.a     = MA_W'(v_reg);
                mac_op.b     = $signed({2'b00, cfg.wet_mix});
            end
            // wet product is split: high part shifted up, low part unsigned
            S_X_HI:
            begin
                mac_op.issue = 1'b1;
                mac_op.clr   = 1'b1;
                mac_op.sh    = SH_17;
                mac_op.a     = MA_W'(acc >>> 17);
                mac_op.b     = $signed({2'b00, cfg.wet_scale});
            end
            S_X_LO:
            begin
                mac_op.issue = 1'b1;
                mac_op.a     = $signed({(MA_W - 17)'(0), acc[16:0]});
                mac_op.b     = $signed({2'b00, cfg.wet_scale});
            end
            S_X_DRY:
            begin
                mac_op.issue = 1'b1;
                mac_op.sh    = SH_12;
                mac_op.a     = MA_W'(dry);
                mac_op.b     = $signed({1'b0, one_m_mix});
            end
            default:
            begin
                mac_op.issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            ch_reg    <= 1'b0;
            k_reg     <= '0;
            left_reg  <= '0;
            right_reg <= '0;
            last_reg  <= 1'b0;
            mono_reg  <= '0;
            st_reg    <= '0;
            sum_reg   <= '0;
            v_reg     <= '0;
            res_l_reg <= '0;
            res_r_reg <= '0;
            for (int i = 0; i < 16; i++)
            begin
                damp_reg[i] <= '0;
                cpos_reg[i] <= '0;
            end
            for (int i = 0; i < 8; i++)
            begin
                apos_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CRA_W'(1);
                    if (clr_reg == CRA_W'(CR_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        left_reg  <= left_in;
                        right_reg <= right_in;
                        last_reg  <= last_in;
                        mono_reg  <= lr_sum[16:1];
                        ch_reg    <= 1'b0;
                        k_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_C_RD;
                    end
                end
                S_C_RD:
                begin
                    state_reg <= S_C_M1;
                end
                S_C_M1:
                begin
                    sum_reg   <= sum_reg + SUM_W'(comb_rd);
                    state_reg <= S_C_M2;
                end
                S_C_M2:
                begin
                    state_reg <= S_C_W1;
                end
                S_C_W1:
                begin
                    state_reg <= S_C_ST;
                end
                S_C_ST:
                begin
                    damp_reg[cidx] <= st_val;
                    st_reg         <= st_val;
                    state_reg      <= S_C_M3;
                end
                S_C_M3:
                begin
                    state_reg <= S_C_W2;
                end
                S_C_W2:
                begin
                    state_reg <= S_C_WR;
                end
                S_C_WR:
                begin
                    cpos_reg[cidx] <= cpos_next;
                    if (k_reg == K_W'(COMB_COUNT - 1))
                    begin
                        k_reg     <= '0;
                        v_reg     <= sum_sat;
                        state_reg <= S_A_RD;
                    end
                    else
                    begin
                        k_reg     <= k_reg + K_W'(1);
                        state_reg <= S_C_RD;
                    end
                end
                S_A_RD:
                begin
                    state_reg <= S_A_WR;
                end
                S_A_WR:
                begin
                    v_reg          <= ap_out;
                    apos_reg[aidx] <= apos_next;
                    if (k_reg == K_W'(ALLPASS_COUNT - 1))
                    begin
                        k_reg     <= '0;
                        state_reg <= S_X_M1;
                    end
                    else
                    begin
                        k_reg     <= k_reg + K_W'(1);
                        state_reg <= S_A_RD;
                    end
                end
                S_X_M1:
                begin
                    state_reg <= S_X_W1;
                end
                S_X_W1:
                begin
                    state_reg <= S_X_HI;
                end
                S_X_HI:
                begin
                    state_reg <= S_X_LO;
                end
                S_X_LO:
                begin
                    state_reg <= S_X_DRY;
                end
                S_X_DRY:
                begin
                    state_reg <= S_X_W2;
                end
                S_X_W2:
                begin
                    state_reg <= S_X_OUT;
                end
                S_X_OUT:
                begin
                    if (!ch_reg)
                    begin
                        res_l_reg <= mix_val;
                        ch_reg    <= 1'b1;
                        sum_reg   <= '0;
                        state_reg <= S_C_RD;
                    end
                    else
                    begin
                        res_r_reg <= mix_val;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (fin_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign fin_valid = (state_reg == S_DONE);
    assign fin.left  = res_l_reg;
    assign fin.right = res_r_reg;
    assign fin.last  = last_reg;

    genvar gi;
    for (gi = 0; gi < 16; gi++)
    begin : g_pos
        `SCR_ASSERT(a_cpos_range, cpos_reg[gi] < COMB_LEN[gi])
    end

    `SCR_ASSERT(a_comb_idx, (state_reg == S_C_RD) |-> (k_reg < K_W'(COMB_COUNT)))
    `SCR_ASSERT(a_clear_exit, ($past(clearing) && !clearing) |-> (state_reg == S_IDLE))
    `SCR_ASSERT(a_fin_hold, (fin_valid && !fin_ready) |=> fin_valid)

endmodule

/* sv/stereo_comb_allpass_reverb_top.sv */
`timescale 1ns / 1ps
`include "stereo_comb_allpass_reverb_top_defines.svh"
// Stereo reverb: eight damped feedback combs and four allpasses per channel.
// Input channel: in_valid/in_ready carry one stereo frame (left_in, right_in,
// last_in). Output channel: out_valid/out_ready carry one mixed frame
// (left_out, right_out, last_out); exactly one result per input frame.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 feedback, 1 damping, 2 wet mix, 3 wet scale); other indexes are ignored.
// Write only while no frame is in flight.
// Each frame runs the comb, allpass and mix steps for the left channel, then
// for the right; in_ready stays low meanwhile, so a new frame is taken only
// once the last one has left the core. The pace is set by the one
// multiply-accumulate unit shared by the combs and the output mix, and by
// the single port of each delay-line memory.
// Reset: registers take their defaults, then a clearing pass zeroes all delay
// lines, with in_ready low.
// Stall: a finished frame sits in the output register; the next frame is
// accepted and processed meanwhile, and waits in the core until the output
// register is free.
module stereo_comb_allpass_reverb_top import scr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] left_in,
    input  logic signed [15:0] right_in,
    input  logic               last_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] left_out,
    output logic signed [15:0] right_out,
    output logic               last_out,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_wdata
);

    scr_cfg_t cfg_reg;
    scr_res_t fin;
    scr_res_t res_reg;
    logic     out_valid_reg;
    logic     fin_valid;
    logic     fin_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.room_feedback <= 16'd32768;
            cfg_reg.damping_gain  <= 16'd32768;
            cfg_reg.wet_mix       <= 16'd0;
            cfg_reg.wet_scale     <= 16'd12288;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROOM_FEEDBACK: cfg_reg.room_feedback <= cfg_wdata;
                CFG_DAMPING_GAIN:  cfg_reg.damping_gain  <= cfg_wdata;
                CFG_WET_MIX:       cfg_reg.wet_mix       <= cfg_wdata;
                CFG_WET_SCALE:     cfg_reg.wet_scale     <= cfg_wdata;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    scr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .left_in   (left_in),
        .right_in  (right_in),
        .last_in   (last_in),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin)
    );

    assign fin_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else if (fin_valid && fin_ready)
        begin
            out_valid_reg <= 1'b1;
            res_reg       <= fin;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = res_reg.left;
    assign right_out = res_reg.right;
    assign last_out  = res_reg.last;

    `SCR_ASSERT_RST(a_rst_out, !rst_n |-> !out_valid_reg)
    `SCR_ASSERT(a_fin_load, (fin_valid && fin_ready) |=> out_valid_reg)
    `SCR_ASSERT(a_busy_excl, in_ready |-> !fin_valid)

endmodule
